@@ rtl/cfs_pkg.sv @@
// Shared types, constants and character tests for the chat format code stripper.
// Used by every module of the block; depends on nothing else.
package cfs_pkg;

  // Width of one character of text and of one held character.
  localparam int CHAR_W     = 16;
  localparam int HELD_W     = 8;
  // Held characters: a comma and up to five hex digits, so never more than six at once.
  localparam int HOLD_DEPTH = 6;
  localparam int HCNT_W     = 3;
  // Default depth of the queue between the parser and the output side.
  localparam int QUEUE_DEPTH_DEF = 4;

  // Characters that steer the parser.
  localparam logic [CHAR_W-1:0] CHAR_COLOUR = 16'h0003;
  localparam logic [CHAR_W-1:0] CHAR_HEXCOL = 16'h0004;
  localparam logic [CHAR_W-1:0] CHAR_SPACE  = 16'h0020;
  localparam logic [CHAR_W-1:0] CHAR_TAB    = 16'h0009;
  localparam logic [CHAR_W-1:0] CHAR_COMMA  = 16'h002C;

  // Parser modes.
  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_FG,
    MODE_COMMA03,
    MODE_BG,
    MODE_HEX1,
    MODE_HEXCOMMA,
    MODE_HEX2
  } mode_t;

  typedef logic [HELD_W-1:0] held_arr_t [HOLD_DEPTH];

  // One queued job: what one accepted word produces on the output side.
  // Held characters come first when held_first is set, otherwise after the character.
  typedef struct packed {
    logic [HOLD_DEPTH-1:0][HELD_W-1:0] held;
    logic [HCNT_W-1:0]                 n_held;
    logic                              held_first;
    logic                              emit_c;
    logic [CHAR_W-1:0]                 ch;
  } job_t;

  // Queue status seen by the two sides.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // ASCII decimal digit.
  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    is_digit = (c >= 16'h0030) && (c <= 16'h0039);
  endfunction

  // ASCII hex digit, either case.
  function automatic logic is_hex(input logic [CHAR_W-1:0] c);
    is_hex = is_digit(c) || ((c >= 16'h0041) && (c <= 16'h0046)) ||
             ((c >= 16'h0061) && (c <= 16'h0066));
  endfunction

endpackage

@@ rtl/cfs_front.sv @@
// Parser front end: accepts input words, tracks the formatting-code state and
// builds one output job per word that produces text. Depends on cfs_pkg.
module cfs_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       accept,
  input  logic [cfs_pkg::CHAR_W-1:0] c,
  input  logic                       eom,
  output logic                       push,
  output cfs_pkg::job_t              job
);

  cfs_pkg::mode_t               mode_r, mode_nxt;
  logic [1:0]                   dig_r, dig_nxt;
  logic [cfs_pkg::HCNT_W-1:0]   hcnt_r, hcnt_nxt, hcnt_mid;
  cfs_pkg::held_arr_t           held_r, held_nxt;
  logic                         leave, plain, hold_en, emit_c;

  // Next state and job contents for the word on the input.
  always_comb begin
    mode_nxt = mode_r;
    dig_nxt  = dig_r;
    hcnt_nxt = hcnt_r;
    held_nxt = held_r;
    leave    = 1'b0;
    plain    = 1'b0;
    hold_en  = 1'b0;
    emit_c   = 1'b0;

    unique case (mode_r)
      cfs_pkg::MODE_FG: begin
        if (cfs_pkg::is_digit(c) && dig_r < 2'd2) begin
          dig_nxt = dig_r + 2'd1;
        end else if (c == cfs_pkg::CHAR_COMMA && dig_r != 2'd0) begin
          hcnt_nxt    = '0;
          held_nxt[0] = c[cfs_pkg::HELD_W-1:0];
          hcnt_nxt    = 3'd1;
          mode_nxt    = cfs_pkg::MODE_COMMA03;
        end else begin
          leave = 1'b1;
        end
      end
      cfs_pkg::MODE_COMMA03: begin
        if (cfs_pkg::is_digit(c)) begin
          hcnt_nxt = '0;
          mode_nxt = cfs_pkg::MODE_BG;
          dig_nxt  = 2'd1;
        end else begin
          leave = 1'b1;
        end
      end
      cfs_pkg::MODE_BG: begin
        if (cfs_pkg::is_digit(c) && dig_r < 2'd2) begin
          dig_nxt = dig_r + 2'd1;
        end else begin
          leave = 1'b1;
        end
      end
      cfs_pkg::MODE_HEX1: begin
        if (cfs_pkg::is_hex(c)) begin
          if (hcnt_r >= 3'd5) begin
            hcnt_nxt = '0;
            mode_nxt = cfs_pkg::MODE_HEXCOMMA;
          end else begin
            hold_en = 1'b1;
          end
        end else begin
          leave = 1'b1;
        end
      end
      cfs_pkg::MODE_HEXCOMMA: begin
        if (c == cfs_pkg::CHAR_COMMA) begin
          held_nxt[0] = c[cfs_pkg::HELD_W-1:0];
          hcnt_nxt    = 3'd1;
          mode_nxt    = cfs_pkg::MODE_HEX2;
        end else begin
          leave = 1'b1;
        end
      end
      cfs_pkg::MODE_HEX2: begin
        if (cfs_pkg::is_hex(c)) begin
          if (hcnt_r >= 3'd6) begin
            hcnt_nxt = '0;
            mode_nxt = cfs_pkg::MODE_IDLE;
          end else begin
            hold_en = 1'b1;
          end
        end else begin
          leave = 1'b1;
        end
      end
      default: begin
        mode_nxt = cfs_pkg::MODE_IDLE;
        dig_nxt  = 2'd0;
        hcnt_nxt = '0;
        plain    = 1'b1;
      end
    endcase

    // Append a hex digit or comma to the held characters.
    if (hold_en) begin
      for (int i = 0; i < cfs_pkg::HOLD_DEPTH; i++) begin
        if (hcnt_r == cfs_pkg::HCNT_W'(i)) begin
          held_nxt[i] = c[cfs_pkg::HELD_W-1:0];
        end
      end
      hcnt_nxt = hcnt_r + 3'd1;
    end

    // A failed sequence flushes what was held and treats the word as text.
    if (leave) begin
      hcnt_nxt = '0;
      mode_nxt = cfs_pkg::MODE_IDLE;
      dig_nxt  = 2'd0;
      plain    = 1'b1;
    end

    // Ordinary text: code openers, dropped controls and kept characters.
    if (plain) begin
      if (c == cfs_pkg::CHAR_COLOUR) begin
        mode_nxt = cfs_pkg::MODE_FG;
        dig_nxt  = 2'd0;
      end else if (c == cfs_pkg::CHAR_HEXCOL) begin
        mode_nxt = cfs_pkg::MODE_HEX1;
        hcnt_nxt = '0;
      end else if (c < cfs_pkg::CHAR_SPACE && c != cfs_pkg::CHAR_TAB) begin
        emit_c = 1'b0;
      end else begin
        emit_c = 1'b1;
      end
    end

    hcnt_mid = hcnt_nxt;

    // End of message: everything still held goes out after the word.
    if (eom) begin
      hcnt_nxt = '0;
      mode_nxt = cfs_pkg::MODE_IDLE;
      dig_nxt  = 2'd0;
    end

    // Build the job; a failed sequence and an end of message never both flush.
    job.ch         = c;
    job.emit_c     = emit_c;
    job.held_first = leave;
    for (int i = 0; i < cfs_pkg::HOLD_DEPTH; i++) begin
      job.held[i] = leave ? held_r[i] : held_nxt[i];
    end
    if (leave) begin
      job.n_held = hcnt_r;
    end else if (eom) begin
      job.n_held = hcnt_mid;
    end else begin
      job.n_held = '0;
    end
  end

  assign push = accept && (emit_c || job.n_held != '0);

  // Parser control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= cfs_pkg::MODE_IDLE;
      dig_r  <= 2'd0;
      hcnt_r <= '0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      dig_r  <= dig_nxt;
      hcnt_r <= hcnt_nxt;
    end
  end

  // Held characters carry no reset; only written entries are ever read.
  always_ff @(posedge clk) begin
    if (accept) begin
      held_r <= held_nxt;
    end
  end

`ifndef SYNTHESIS
  a_hcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    hcnt_r <= 3'(cfs_pkg::HOLD_DEPTH))
    else $error("held count beyond the hold depth");

  a_comma_held: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == cfs_pkg::MODE_COMMA03) |-> (hcnt_r == 3'd1))
    else $error("colour comma mode without exactly one held comma");

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && eom) |=> (mode_r == cfs_pkg::MODE_IDLE && hcnt_r == '0))
    else $error("parser not idle and empty after end of message");
`endif

endmodule

@@ rtl/cfs_queue.sv @@
// Short job queue between the parser and the output side.
// Depends on cfs_pkg for the job type and the status struct.
module cfs_queue #(
  parameter int DEPTH = cfs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  cfs_pkg::job_t        push_job,
  input  logic                 pop,
  output cfs_pkg::job_t        head_job,
  output cfs_pkg::q_status_t   status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cfs_pkg::job_t      slots_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r;

  assign status.full  = (count_r == CNT_W'(DEPTH));
  assign status.empty = (count_r == '0);
  assign head_job     = slots_r[rd_ptr_r];

  // Job storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !status.full)
    else $error("job pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !status.empty)
    else $error("job popped from an empty queue");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count beyond its depth");
`endif

endmodule

@@ rtl/cfs_back.sv @@
// Output side: walks the head job character by character into the output register.
// Depends on cfs_pkg for the job type and the status struct.
module cfs_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cfs_pkg::job_t              head_job,
  input  cfs_pkg::q_status_t         status,
  output logic                       pop,
  input  logic                       out_stall,
  output logic                       out_valid,
  output logic [cfs_pkg::CHAR_W-1:0] out_char,
  output logic                       out_run_last
);

  logic [cfs_pkg::HCNT_W-1:0]  idx_r;
  logic [cfs_pkg::HCNT_W-1:0]  n_total, sel;
  logic                        use_c, is_last, load;
  logic [cfs_pkg::HELD_W-1:0]  held_val;
  logic [cfs_pkg::CHAR_W-1:0]  char_nxt;
  logic                        out_valid_r, out_last_r;
  logic [cfs_pkg::CHAR_W-1:0]  out_char_r;

  // Pick the character at the current position of the head job.
  always_comb begin
    n_total = head_job.n_held + {2'b00, head_job.emit_c};
    if (head_job.held_first) begin
      use_c = (idx_r >= head_job.n_held);
      sel   = idx_r;
    end else begin
      use_c = head_job.emit_c && (idx_r == '0);
      sel   = idx_r - {2'b00, head_job.emit_c};
    end
    held_val = '0;
    for (int i = 0; i < cfs_pkg::HOLD_DEPTH; i++) begin
      if (sel == cfs_pkg::HCNT_W'(i)) begin
        held_val = head_job.held[i];
      end
    end
    char_nxt = use_c ? head_job.ch : {{(cfs_pkg::CHAR_W - cfs_pkg::HELD_W){1'b0}}, held_val};
    is_last  = (idx_r == n_total - 3'd1);
  end

  // The output register takes a new word when it is empty or being taken.
  assign load = !status.empty && (!out_valid_r || !out_stall);
  assign pop  = load && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        idx_r       <= is_last ? '0 : idx_r + 3'd1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (load) begin
      out_char_r <= char_nxt;
      out_last_r <= is_last;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_char     = out_char_r;
  assign out_run_last = out_last_r;

`ifndef SYNTHESIS
  a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
    !status.empty |-> (idx_r < n_total))
    else $error("position beyond the head job's results");

  a_idle_idx: assert property (@(posedge clk) disable iff (!rst_n)
    status.empty |-> (idx_r == '0))
    else $error("position not cleared with the queue empty");

  a_pop_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (out_valid_r && out_last_r))
    else $error("job finished without a last word on the output");
`endif

endmodule

@@ rtl/chat_format_code_stripper.sv @@
// Top level of the chat format code stripper: parser, job queue and output side.
// Depends on cfs_pkg, cfs_front, cfs_queue and cfs_back.
//
//   Channel  Ports                                   Handshake
//   input    in_char, in_end_of_message              in_valid / in_stall
//   output   out_char, out_run_last                  out_valid / out_stall
//
// One input word is accepted per cycle while the job queue has room.
// Each word yields zero to seven output words, one per cycle from the output
// register unless stalled, held characters flushed at a failed code or message end included.
// Input stalls only when the QUEUE_DEPTH-entry job queue is full.
// Reset is synchronous and active low; it empties the queue and idles the parser.
module chat_format_code_stripper #(
  parameter int QUEUE_DEPTH = cfs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [cfs_pkg::CHAR_W-1:0] in_char,
  input  logic                       in_end_of_message,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [cfs_pkg::CHAR_W-1:0] out_char,
  output logic                       out_run_last
);

  logic               accept, push, pop;
  cfs_pkg::job_t      push_job, head_job;
  cfs_pkg::q_status_t q_status;

  assign in_stall = q_status.full;
  assign accept   = in_valid && !q_status.full;

  cfs_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .c      (in_char),
    .eom    (in_end_of_message),
    .push   (push),
    .job    (push_job)
  );

  cfs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .status   (q_status)
  );

  cfs_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_job     (head_job),
    .status       (q_status),
    .pop          (pop),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .out_char     (out_char),
    .out_run_last (out_run_last)
  );

endmodule
